### design/ptpq_pkg.sv
// shared types and constants of the periodic timer priority queue
`default_nettype none

package ptpq_pkg;

  localparam int unsigned TimeBits   = 48;
  localparam int unsigned HandleBits = 8;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned IdxW       = $clog2(MaxResults);
  localparam int unsigned NpopW      = $clog2(MaxResults + 1);

  localparam logic OpAdd  = 1'b0;
  localparam logic OpPoll = 1'b1;

  localparam logic [1:0] KindAck   = 2'd0;
  localparam logic [1:0] KindFired = 2'd1;
  localparam logic [1:0] KindNone  = 2'd2;

  typedef struct packed {
    logic                  opcode;
    logic [HandleBits-1:0] timer_id;
    logic [TimeBits-1:0]   expire_time;
    logic [TimeBits-1:0]   interval_us;
    logic [TimeBits-1:0]   now_us;
  } item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [HandleBits-1:0] fired_id;
    logic                  add_status;
    logic                  became_earliest;
    logic [TimeBits-1:0]   next_expire;
    logic                  queue_empty;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic            load;
    logic            insert;
    logic            pop;
    logic            sum;
    logic            emit_ack;
    logic            emit_fire;
    logic            emit_none;
    logic            last;
    logic [IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic head_due;
    logic iv_nz;
  } sts_t;

endpackage

`default_nettype wire

### design/ptpq_ctrl.sv
// sequencing state machine of the periodic timer priority queue
`default_nettype none

module ptpq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire logic           opcode_i,
  output logic                busy,
  output ptpq_pkg::cmd_t      cmd_o,
  input  wire ptpq_pkg::sts_t sts_i
);
  import ptpq_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StAdd,
    StAck,
    StPop,
    StSum,
    StRearm,
    StEmit,
    StNone
  } state_e;

  state_e           state_q;
  logic [NpopW-1:0] npop_q;
  logic [IdxW-1:0]  idx_q;
  logic             can_pop;
  logic             idx_last;

  assign busy     = (state_q != StIdle);
  assign can_pop  = sts_i.head_due && (npop_q < NpopW'(MaxResults));
  assign idx_last = ({1'b0, idx_q} + NpopW'(1)) == npop_q;

  always_comb begin
    cmd_o     = '0;
    cmd_o.idx = idx_q;
    case (state_q)
      StIdle: begin
        cmd_o.load = start;
      end
      StAdd: begin
        cmd_o.insert = 1'b1;
      end
      StAck: begin
        cmd_o.emit_ack = 1'b1;
        cmd_o.last     = 1'b1;
      end
      StPop: begin
        cmd_o.pop = can_pop;
        cmd_o.idx = npop_q[IdxW-1:0];
      end
      StSum: begin
        cmd_o.sum = 1'b1;
      end
      StRearm: begin
        cmd_o.insert = sts_i.iv_nz;
      end
      StEmit: begin
        cmd_o.emit_fire = 1'b1;
        cmd_o.last      = idx_last;
      end
      StNone: begin
        cmd_o.emit_none = 1'b1;
        cmd_o.last      = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      npop_q  <= '0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (start) begin
            npop_q  <= '0;
            idx_q   <= '0;
            state_q <= (opcode_i == OpAdd) ? StAdd : StPop;
          end
        end
        StAdd: begin
          state_q <= StAck;
        end
        StAck: begin
          state_q <= StIdle;
        end
        StPop: begin
          if (can_pop) begin
            npop_q <= npop_q + NpopW'(1);
          end else if (npop_q == '0) begin
            state_q <= StNone;
          end else begin
            idx_q   <= '0;
            state_q <= StSum;
          end
        end
        StSum: begin
          state_q <= StRearm;
        end
        StRearm: begin
          if (idx_last) begin
            idx_q   <= '0;
            state_q <= StEmit;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= StSum;
          end
        end
        StEmit: begin
          if (idx_last) begin
            state_q <= StIdle;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        StNone: begin
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/ptpq_dp.sv
// sorted timer store, pop buffer and result register
`default_nettype none

module ptpq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ptpq_pkg::item_t item_i,
  input  wire ptpq_pkg::cmd_t  cmd_i,
  output ptpq_pkg::sts_t       sts_o,
  output ptpq_pkg::result_t    result_o,
  output logic                 result_valid_o
);
  import ptpq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [TimeBits-1:0]   exp_q [DEPTH];
  logic [TimeBits-1:0]   iv_q  [DEPTH];
  logic [HandleBits-1:0] hdl_q [DEPTH];
  logic [CntW-1:0]       cnt_q;

  logic [TimeBits-1:0]   biv_q [MaxResults];
  logic [HandleBits-1:0] bh_q  [MaxResults];

  logic [TimeBits-1:0]   now_q;
  logic [TimeBits-1:0]   key_q;
  logic [TimeBits-1:0]   niv_q;
  logic [HandleBits-1:0] nh_q;
  logic                  full_q;
  logic                  first_q;
  result_t               res_q;
  logic                  res_vld_q;

  logic [DEPTH-1:0]      le;
  logic                  full;
  logic                  empty;
  logic                  do_ins;
  logic                  emit_any;
  logic [TimeBits:0]     sum;
  result_t               res_d;

  assign full     = (cnt_q == CntW'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign do_ins   = cmd_i.insert && !full;
  assign emit_any = cmd_i.emit_ack || cmd_i.emit_fire || cmd_i.emit_none;
  assign sum      = {1'b0, now_q} + {1'b0, biv_q[cmd_i.idx]};

  // entries at or before the new key stay in place
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CntW'(i) < cnt_q) && (exp_q[i] <= key_q);
    end
  end

  assign sts_o.head_due = !empty && (exp_q[0] <= now_q);
  assign sts_o.iv_nz    = (biv_q[cmd_i.idx] != '0);

  always_comb begin
    res_d                 = '0;
    res_d.kind            = cmd_i.emit_ack  ? KindAck :
                            cmd_i.emit_fire ? KindFired : KindNone;
    res_d.fired_id        = cmd_i.emit_fire ? bh_q[cmd_i.idx] : '0;
    res_d.add_status      = cmd_i.emit_ack && full_q;
    res_d.became_earliest = cmd_i.emit_ack && !full_q && first_q;
    res_d.next_expire     = empty ? '0 : exp_q[0];
    res_d.queue_empty     = empty;
    res_d.last            = cmd_i.last;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= item_i.expire_time;
      niv_q <= item_i.interval_us;
      nh_q  <= item_i.timer_id;
      now_q <= item_i.now_us;
    end
    if (cmd_i.sum) begin
      key_q <= sum[TimeBits] ? '1 : sum[TimeBits-1:0];
      niv_q <= biv_q[cmd_i.idx];
      nh_q  <= bh_q[cmd_i.idx];
    end
    if (cmd_i.insert) begin
      full_q  <= full;
      first_q <= !le[0];
    end
    if (cmd_i.pop) begin
      biv_q[cmd_i.idx] <= iv_q[0];
      bh_q[cmd_i.idx]  <= hdl_q[0];
      for (int i = 0; i < DEPTH - 1; i++) begin
        exp_q[i] <= exp_q[i+1];
        iv_q[i]  <= iv_q[i+1];
        hdl_q[i] <= hdl_q[i+1];
      end
    end
    if (do_ins) begin
      if (!le[0]) begin
        exp_q[0] <= key_q;
        iv_q[0]  <= niv_q;
        hdl_q[0] <= nh_q;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (!le[i]) begin
          if (le[i-1]) begin
            exp_q[i] <= key_q;
            iv_q[i]  <= niv_q;
            hdl_q[i] <= nh_q;
          end else begin
            exp_q[i] <= exp_q[i-1];
            iv_q[i]  <= iv_q[i-1];
            hdl_q[i] <= hdl_q[i-1];
          end
        end
      end
    end
    if (emit_any) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= emit_any;
      if (cmd_i.pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end else if (do_ins) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("pending count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !empty)
    else $error("pop from empty queue");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.insert && full) |=> $stable(cnt_q))
    else $error("insert into full queue changed count");

endmodule

`default_nettype wire

### design/periodic_timer_priority_queue_unit.sv
// top level of the periodic timer priority queue
//
// channel   direction  handshake                 payload
// item      in         start && !busy            item_i   (ptpq_pkg::item_t)
// result    out        result_valid_o, 1 cycle   result_o (ptpq_pkg::result_t)
//
// add: an insert step, then the acknowledgement step; busy through both
// poll: one pop per cycle while the head is due, up to MaxResults, then a closing check;
// with nothing popped a none result follows, else a sum and a re-arm step per popped
// timer, then one result per cycle from the pop buffer
// reset empties the queue at once, no clearing pass
// results cannot be stalled; a new transaction may start while the last one shows
`default_nettype none

module periodic_timer_priority_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire ptpq_pkg::item_t item_i,
  output ptpq_pkg::result_t    result_o,
  output logic                 result_valid_o
);
  import ptpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ptpq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (item_i.opcode),
    .busy     (busy),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  ptpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

`default_nettype wire

### tb/tb.sv
// testbench for periodic_timer_priority_queue_unit: directed table then random adds and polls
`timescale 1ns / 100ps

module tb;
  import ptpq_pkg::*;

  localparam int Depth = 16;
  localparam logic [TimeBits-1:0] TMax = '1;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  result_t result_o;
  logic    result_valid_o;

  periodic_timer_priority_queue_unit #(
    .DEPTH(Depth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sorted timer store of the predictor
  logic [TimeBits-1:0]   tq_expire[Depth];
  logic [TimeBits-1:0]   tq_iv[Depth];
  logic [HandleBits-1:0] tq_id[Depth];
  int                    tq_count = 0;

  result_t results_due[$];
  result_t want_r;
  int      idle_pct;
  int      mismatches    = 0;
  int      n_items       = 0;
  int      results_seen  = 0;
  int      fired_seen    = 0;
  int      rejected_seen = 0;

  function automatic logic [TimeBits-1:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic item_t add_item(input logic [HandleBits-1:0] id,
                                     input logic [TimeBits-1:0] t,
                                     input logic [TimeBits-1:0] iv);
    item_t it;
    it             = '0;
    it.opcode      = OpAdd;
    it.timer_id    = id;
    it.expire_time = t;
    it.interval_us = iv;
    return it;
  endfunction

  function automatic item_t poll_item(input logic [TimeBits-1:0] now);
    item_t it;
    it        = '0;
    it.opcode = OpPoll;
    it.now_us = now;
    return it;
  endfunction

  function automatic result_t single(input logic [1:0] kind, input logic st,
                                     input logic be, input logic [TimeBits-1:0] nxt,
                                     input logic empty);
    result_t r;
    r                 = '0;
    r.kind            = kind;
    r.add_status      = st;
    r.became_earliest = be;
    r.next_expire     = nxt;
    r.queue_empty     = empty;
    r.last            = 1'b1;
    return r;
  endfunction

  function automatic bit tq_insert(input logic [TimeBits-1:0] t,
                                   input logic [TimeBits-1:0] iv,
                                   input logic [HandleBits-1:0] h);
    int pos;
    bit first;
    first = (tq_count == 0) || (t < tq_expire[0]);
    pos   = 0;
    while (pos < tq_count && tq_expire[pos] <= t) pos++;
    for (int i = tq_count; i > pos; i--) begin
      tq_expire[i] = tq_expire[i-1];
      tq_iv[i]     = tq_iv[i-1];
      tq_id[i]     = tq_id[i-1];
    end
    tq_expire[pos] = t;
    tq_iv[pos]     = iv;
    tq_id[pos]     = h;
    tq_count++;
    return first;
  endfunction

  task automatic step_timer_queue(input item_t it, input bit typed, input result_t want);
    result_t               outs[$];
    result_t               r;
    logic [TimeBits-1:0]   pop_iv[$];
    logic [HandleBits-1:0] pop_id[$];
    logic [TimeBits:0]     sum;
    if (it.opcode == OpAdd) begin
      r      = '0;
      r.kind = KindAck;
      if (tq_count >= Depth) begin
        r.add_status = 1'b1;
      end else begin
        r.became_earliest = tq_insert(it.expire_time, it.interval_us, it.timer_id);
      end
      outs.push_back(r);
    end else begin
      while (outs.size() < MaxResults && tq_count > 0 && tq_expire[0] <= it.now_us) begin
        r          = '0;
        r.kind     = KindFired;
        r.fired_id = tq_id[0];
        outs.push_back(r);
        pop_iv.push_back(tq_iv[0]);
        pop_id.push_back(tq_id[0]);
        for (int i = 1; i < tq_count; i++) begin
          tq_expire[i-1] = tq_expire[i];
          tq_iv[i-1]     = tq_iv[i];
          tq_id[i-1]     = tq_id[i];
        end
        tq_count--;
      end
      // re-arm periodic timers in pop order, saturating at the maximum time
      foreach (pop_iv[i]) begin
        if (pop_iv[i] != '0 && tq_count < Depth) begin
          sum = {1'b0, it.now_us} + {1'b0, pop_iv[i]};
          void'(tq_insert(sum[TimeBits] ? TMax : sum[TimeBits-1:0], pop_iv[i], pop_id[i]));
        end
      end
      if (outs.size() == 0) begin
        r      = '0;
        r.kind = KindNone;
        outs.push_back(r);
      end
    end
    foreach (outs[k]) begin
      outs[k].queue_empty = (tq_count == 0);
      outs[k].next_expire = (tq_count == 0) ? '0 : tq_expire[0];
      outs[k].last        = (k == outs.size() - 1);
    end
    if (typed) results_due.push_back(want);
    else foreach (outs[k]) results_due.push_back(outs[k]);
  endtask

  task automatic issue(input item_t it, input bit typed, input result_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    step_timer_queue(it, typed, want);
    n_items++;
  endtask

  task automatic cmp(input string fname, input logic [TimeBits-1:0] e,
                     input logic [TimeBits-1:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %h, got %h", $time, fname, e, a);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (result_o.kind == KindFired) fired_seen++;
      if (result_o.kind == KindAck && result_o.add_status) rejected_seen++;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got %h", $time, result_o);
        mismatches++;
      end else begin
        want_r = results_due.pop_front();
        cmp("kind", 48'(want_r.kind), 48'(result_o.kind));
        cmp("fired_id", 48'(want_r.fired_id), 48'(result_o.fired_id));
        cmp("add_status", 48'(want_r.add_status), 48'(result_o.add_status));
        cmp("became_earliest", 48'(want_r.became_earliest), 48'(result_o.became_earliest));
        cmp("next_expire", want_r.next_expire, result_o.next_expire);
        cmp("queue_empty", 48'(want_r.queue_empty), 48'(result_o.queue_empty));
        cmp("last", 48'(want_r.last), 48'(result_o.last));
      end
    end
  end

  initial begin
    #(3_000_000);
    $display("timeout with %0d transactions still awaited", results_due.size());
    $display("** periodic_timer_priority_queue_unit: FAILED **");
    $finish;
  end

  initial begin
    stim_row_t           rows[$];
    item_t               it;
    logic [TimeBits-1:0] clock_us;
    int                  waited;
    int                  r;

    rst_ni <= 1'b0;
    start  <= 1'b0;
    item_i <= '0;

    // empty queue, extremes, ties, full queue, saturated re-arm
    rows.push_back('{poll_item('0), 1'b1, single(KindNone, 1'b0, 1'b0, '0, 1'b1)});
    rows.push_back('{poll_item(TMax), 1'b1, single(KindNone, 1'b0, 1'b0, '0, 1'b1)});
    rows.push_back('{add_item(8'hff, TMax, '0), 1'b1,
                     single(KindAck, 1'b0, 1'b1, TMax, 1'b0)});
    rows.push_back('{add_item(8'h00, '0, TMax), 1'b1,
                     single(KindAck, 1'b0, 1'b1, '0, 1'b0)});
    rows.push_back('{add_item(8'h01, '0, '0), 1'b1,
                     single(KindAck, 1'b0, 1'b0, '0, 1'b0)});
    rows.push_back('{poll_item('0), 1'b0, '0});
    for (int k = 1; k <= 14; k++) begin
      rows.push_back('{add_item(8'(8'h10 + k), 48'(100 * k), (k == 3) ? 48'd7 : 48'd0),
                       1'b0, '0});
    end
    rows.push_back('{add_item(8'haa, 48'd5, '0), 1'b1,
                     single(KindAck, 1'b1, 1'b0, 48'd100, 1'b0)});
    rows.push_back('{poll_item(48'd1000), 1'b0, '0});
    rows.push_back('{poll_item(TMax), 1'b0, '0});

    idle_pct = 22;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) issue(rows[i].it, rows[i].typed, rows[i].want);

    clock_us = rand48() >> 1;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 22 : (ph == 1) ? 72 : 0;
      repeat ((ph == 2) ? 80 : 85) begin
        it             = '0;
        it.timer_id    = 8'($urandom);
        it.expire_time = rand48();
        it.interval_us = rand48();
        it.now_us      = rand48();
        if ($urandom_range(99) < 58) begin
          it.opcode = OpAdd;
          r = $urandom_range(99);
          if (r < 10) it.expire_time = clock_us;
          else if (r < 20) it.expire_time = clock_us - 48'($urandom_range(1, 300));
          else if (r >= 2) it.expire_time = clock_us + 48'($urandom_range(0, 400));
          r = $urandom_range(99);
          if (r < 45) it.interval_us = '0;
          else it.interval_us = 48'($urandom_range(1, 2000));
        end else begin
          it.opcode = OpPoll;
          r = $urandom_range(99);
          if (r < 4) clock_us += 48'($urandom_range(2000, 30000));
          else clock_us += 48'($urandom_range(0, 150));
          if (r >= 4 && r < 9) it.now_us = clock_us - 48'($urandom_range(1, 500));
          else it.now_us = clock_us;
        end
        issue(it, 1'b0, '0);
      end
      if (ph < 2) begin
        // hold off until every awaited transaction is back
        start <= 1'b0;
        do @(posedge clk_i); while (results_due.size() != 0);
      end
    end

    start <= 1'b0;
    for (waited = 0; results_due.size() != 0 && waited < 5000; waited++) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (results_due.size() != 0) begin
      $display("%0t: %0d transactions never arrived, next expected %h",
               $time, results_due.size(), results_due[0]);
      mismatches++;
    end

    $display("%0d adds and polls sent, %0d transactions checked", n_items, results_seen);
    $display("%0d timers fired, %0d adds rejected on a full queue, %0d mismatches",
             fired_seen, rejected_seen, mismatches);
    if (mismatches == 0) begin
      $display("** periodic_timer_priority_queue_unit: PASSED **");
    end else begin
      $display("** periodic_timer_priority_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
design/ptpq_pkg.sv
design/ptpq_ctrl.sv
design/ptpq_dp.sv
design/periodic_timer_priority_queue_unit.sv
tb/tb.sv
